@@ design/bpnm_pkg.sv @@
`default_nettype none

package bpnm_pkg;

  // default frame geometry and sample width
  localparam int DEF_WIDTH      = 80;
  localparam int DEF_HEIGHT     = 60;
  localparam int DEF_PIXEL_BITS = 16;

  // port field widths
  localparam int VALUE_W = 16;

  // neighbour count holds 0..8
  localparam int CNT_W = 4;

  // word kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [VALUE_W-1:0] pixel_value;
    logic               pixel_bad;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] corrected_value;
    logic               last_of_frame;
  } out_word_t;

endpackage

`default_nettype wire

@@ design/bpnm_line_mem.sv @@
`default_nettype none

module bpnm_line_mem
  import bpnm_pkg::*;
#(
  parameter int DEPTH  = 2 * DEF_WIDTH + 3,
  parameter int ADDR_W = $clog2(2 * DEF_WIDTH + 3),
  parameter int DATA_W = DEF_PIXEL_BITS + 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/bpnm_div.sv @@
`default_nettype none

module bpnm_div
  import bpnm_pkg::*;
#(
  parameter int NUM_W = DEF_PIXEL_BITS + 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [CNT_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  den_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              take;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[NUM_W-1]};
  assign take  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      quo   <= {quo[NUM_W-2:0], take};
      rem   <= take ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ design/bad_pixel_neighbour_mean_fix.sv @@
`default_nettype none
// sequence: a word completing a neighbourhood starts a job; its 9 taps are read in turn,
//   then evaluated; a defective centre with a usable neighbour goes through the mean divider
// throughput: 1 word/cycle while results are not yet due; in_stall holds input off while a
//   job runs, which makes 9 serial reads on the single read port of the line store and
//   waits on any stall of the receiver
// reset: synchronous active-high rst clears control and positions; the line store is not
//   cleared and needs no clearing pass

module bad_pixel_neighbour_mean_fix
  import bpnm_pkg::*;
#(
  parameter int WIDTH      = DEF_WIDTH,
  parameter int HEIGHT     = DEF_HEIGHT,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  // ring holds two lines plus three pixels: enough for the oldest
  // upper neighbour and the newest lower neighbour of a centre
  localparam int RING   = 2 * WIDTH + 3;
  localparam int ADDR_W = $clog2(RING);
  localparam int DATA_W = PIXEL_BITS + 1;
  localparam int PEND_W = $clog2(WIDTH + 3);
  localparam int COL_W  = $clog2(WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int SUM_W  = PIXEL_BITS + 3;
  localparam int K_W    = 4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_WAIT = 6'b000100,
    S_EVAL = 6'b001000,
    S_DIV  = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t state;

  // input side bookkeeping
  logic [ADDR_W-1:0] wp;
  logic [PEND_W-1:0] pending;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;

  // job registers for the pixel being corrected
  logic [ADDR_W-1:0] center;
  logic [8:0]        nb_ok;
  logic              job_last;
  logic [DATA_W-1:0] center_entry;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;
  logic [PIXEL_BITS-1:0] res;

  // read sequencing
  logic [K_W-1:0]    rd_k;
  logic [K_W-1:0]    rd_tag;
  logic              rd_live;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  logic              accept;
  logic              is_pixel;
  logic              emit;
  logic [PEND_W-1:0] pend_e;
  logic [ADDR_W-1:0] center_next;
  logic [8:0]        nb_ok_next;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W:0]   addr_sum;
  logic [DATA_W-1:0] wdata;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_pixel = (in_word.opcode == OP_PIXEL);
  assign out_free = !out_valid || !out_stall;

  // a pixel word emits once at least a line and a pixel are pending;
  // a drain word emits whatever is oldest
  always_comb begin
    if (is_pixel) begin
      emit   = (pending >= PEND_W'(WIDTH + 1));
      pend_e = pending + PEND_W'(1);
    end else begin
      emit   = (pending != '0);
      pend_e = pending;
    end
  end

  // centre slot is the oldest pending entry, same for both word kinds
  always_comb begin
    if (wp >= ADDR_W'(pending)) begin
      center_next = wp - ADDR_W'(pending);
    end else begin
      center_next = ADDR_W'(wp + ADDR_W'(RING) - ADDR_W'(pending));
    end
  end

  // neighbour usable: inside the frame, and already arrived for the right and lower ones
  always_comb begin
    logic up, dn, lf, rt;
    up = (out_row != '0);
    dn = (out_row != ROW_W'(HEIGHT - 1));
    lf = (out_col != '0);
    rt = (out_col != COL_W'(WIDTH - 1));
    nb_ok_next[0] = up && lf;
    nb_ok_next[1] = up;
    nb_ok_next[2] = up && rt;
    nb_ok_next[3] = lf;
    nb_ok_next[4] = 1'b1;
    nb_ok_next[5] = rt && (pend_e > PEND_W'(1));
    nb_ok_next[6] = dn && lf && (pend_e > PEND_W'(WIDTH - 1));
    nb_ok_next[7] = dn && (pend_e > PEND_W'(WIDTH));
    nb_ok_next[8] = dn && rt && (pend_e > PEND_W'(WIDTH + 1));
  end

  // ring offset of each window tap relative to the centre
  always_comb begin
    case (rd_k)
      K_W'(0): offset = ADDR_W'(RING - WIDTH - 1);
      K_W'(1): offset = ADDR_W'(RING - WIDTH);
      K_W'(2): offset = ADDR_W'(RING - WIDTH + 1);
      K_W'(3): offset = ADDR_W'(RING - 1);
      K_W'(5): offset = ADDR_W'(1);
      K_W'(6): offset = ADDR_W'(WIDTH - 1);
      K_W'(7): offset = ADDR_W'(WIDTH);
      K_W'(8): offset = ADDR_W'(WIDTH + 1);
      default: offset = '0;
    endcase
  end

  assign addr_sum = {1'b0, center} + {1'b0, offset};

  always_comb begin
    if (addr_sum >= (ADDR_W + 1)'(RING)) begin
      raddr = ADDR_W'(addr_sum - (ADDR_W + 1)'(RING));
    end else begin
      raddr = addr_sum[ADDR_W-1:0];
    end
  end

  assign wdata = {in_word.pixel_bad, in_word.pixel_value[PIXEL_BITS-1:0]};

  bpnm_line_mem #(
    .DEPTH (RING),
    .ADDR_W(ADDR_W),
    .DATA_W(DATA_W)
  ) u_mem (
    .clk  (clk),
    .we   (accept && is_pixel),
    .waddr(wp),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // mean is only taken for a defective centre with a usable neighbour
  assign div_start = (state == S_EVAL) && center_entry[PIXEL_BITS] && (cnt != '0);

  bpnm_div #(
    .NUM_W(SUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (sum),
    .den  (cnt),
    .done (div_done),
    .quo  (div_quo)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      pending   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      rd_k      <= '0;
      rd_live   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_live <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_pixel) begin
              wp <= (wp == ADDR_W'(RING - 1)) ? '0 : wp + ADDR_W'(1);
              if (!emit) begin
                pending <= pending + PEND_W'(1);
              end
            end else if (emit) begin
              pending <= pending - PEND_W'(1);
            end
            if (emit) begin
              // output position advances when the job is taken
              if (out_col == COL_W'(WIDTH - 1)) begin
                out_col <= '0;
                out_row <= (out_row == ROW_W'(HEIGHT - 1)) ? '0 : out_row + ROW_W'(1);
              end else begin
                out_col <= out_col + COL_W'(1);
              end
              rd_k  <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          rd_live <= 1'b1;
          if (rd_k == K_W'(8)) begin
            state <= S_WAIT;
          end else begin
            rd_k <= rd_k + K_W'(1);
          end
        end
        S_WAIT: begin
          // last tap lands this cycle
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= div_start ? S_DIV : S_HOLD;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // job datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && emit) begin
      center   <= center_next;
      nb_ok    <= nb_ok_next;
      job_last <= (out_col == COL_W'(WIDTH - 1)) && (out_row == ROW_W'(HEIGHT - 1));
      sum      <= '0;
      cnt      <= '0;
    end else if (rd_live) begin
      if (rd_tag == K_W'(4)) begin
        center_entry <= rdata;
      end else if (nb_ok[rd_tag] && !rdata[PIXEL_BITS]) begin
        sum <= sum + SUM_W'(rdata[PIXEL_BITS-1:0]);
        cnt <= cnt + CNT_W'(1);
      end
    end
    if (state == S_READ) begin
      rd_tag <= rd_k;
    end
    if (state == S_EVAL) begin
      res <= center_entry[PIXEL_BITS-1:0];
    end else if (state == S_DIV && div_done) begin
      res <= div_quo[PIXEL_BITS-1:0];
    end
    if (state == S_HOLD && out_free) begin
      out_word.corrected_value <= VALUE_W'(res);
      out_word.last_of_frame   <= job_last;
    end
  end

`ifndef ASSERT_OFF
  // never more pending than a line and a pixel between words
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(WIDTH + 1))
    else $error("pending count out of range");

  // write pointer stays inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < ADDR_W'(RING))
    else $error("write pointer outside ring");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider done outside divide phase");

  // leaving the hold phase always presents a word
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && out_free) |=> out_valid)
    else $error("result lost on leaving hold");
`endif

endmodule

`default_nettype wire
